### hw/rtl/rrts_pkg.sv
// Shared types and constants for the round-robin time-slice scheduler.
// No dependencies.
package rrts_pkg;

   localparam int MAX_TASKS = 64;
   localparam int ID_W      = 6;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   typedef enum logic [2:0] {
      OP_ENQUEUE  = 3'd0,
      OP_DEQUEUE  = 3'd1,
      OP_YIELD    = 3'd2,
      OP_PICK     = 3'd3,
      OP_PUT_PREV = 3'd4,
      OP_TICK     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_NOT_QUEUED = 2'd1,
      ST_FULL       = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_FORE_SLICE   = 2'd0,
      REG_BACK_SLICE   = 2'd1,
      REG_ROUND_BUDGET = 2'd2
   } reg_type;

   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001,
      FSM_READ = 4'b0010,
      FSM_LINK = 4'b0100,
      FSM_RESP = 4'b1000
   } fsm_type;

endpackage

### hw/rtl/round_robin_time_slice_scheduler.sv
// Round-robin time-slice scheduler: run queue kept as a doubly linked list.
// A request passes through read and response states, plus a link state when a task is
// linked into the queue; one item at a time, so a new request is taken only once the
// last response is registered, which waits while a held response awaits rsp_tready.
// Reset (synchronous, active high) empties the queue and clears current task and
// round time; per-task memories hold no reset and need no clearing pass.
// Depends on rrts_pkg.
module round_robin_time_slice_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation, [8:3] task_id, [9] at_head, [10] foreground,
   // [42:11] clock_now, [47:43] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] picked_valid, [6:1] picked_task, [7] resched, [9:8] status, [15:10] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import rrts_pkg::*;

   // Per-task memories
   logic [ID_W-1:0] next_mem_ff [MAX_TASKS];
   logic [ID_W-1:0] prev_mem_ff [MAX_TASKS];
   logic [15:0]     slice_mem_ff [MAX_TASKS];
   logic            fg_mem_ff [MAX_TASKS];

   logic [ID_W-1:0] nx_rd_ff, pv_rd_ff;
   logic [15:0]     sl_rd_ff;
   logic            fg_rd_ff;

   // Control and scalar state
   fsm_type          state_ff, state_in;
   logic [MAX_TASKS-1:0] queued_ff, queued_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [31:0]      round_ff, round_in, start_ff, start_in;
   logic [ID_W-1:0]  cur_task_ff, cur_task_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [15:0]      fore_ff, back_ff;
   logic [31:0]      budget_ff;

   // Latched request
   logic [2:0]      op_ff;
   logic [ID_W-1:0] id_ff;
   logic            head_req_ff, fg_req_ff;
   logic [31:0]     now_ff;

   // Result hold and output register
   logic            res_pv_ff, res_pv_in, res_rs_ff, res_rs_in;
   logic [ID_W-1:0] res_pt_ff, res_pt_in;
   logic [1:0]      res_st_ff, res_st_in;
   logic            rsp_valid_ff;
   logic [15:0]     rsp_data_ff;

   // Memory write controls
   logic            nx_we, pv_we, sl_we, fg_we;
   logic [ID_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
   logic [15:0]     sl_wd;

   logic            req_acc, out_free;
   logic [31:0]     delta, acc_round;
   logic [32:0]     sum;
   logic            acc_rs, do_acc, is_q;
   logic [15:0]     sl_dec, reload;

   assign req_tready = (state_ff == FSM_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Accounting: clamped delta, saturating add
   always_comb begin
      delta = now_ff - start_ff;
      if (delta[31]) begin
         delta = 32'd0;
      end
      sum       = {1'b0, round_ff} + {1'b0, delta};
      acc_round = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      acc_rs    = cur_valid_ff && (acc_round >= budget_ff);
   end

   assign is_q   = queued_ff[id_ff];
   assign sl_dec = sl_rd_ff - 16'd1;
   assign reload = fg_rd_ff ? fore_ff : back_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      queued_in    = queued_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      round_in     = round_ff;
      start_in     = start_ff;
      cur_task_in  = cur_task_ff;
      cur_valid_in = cur_valid_ff;
      res_pv_in    = res_pv_ff;
      res_pt_in    = res_pt_ff;
      res_rs_in    = res_rs_ff;
      res_st_in    = res_st_ff;
      nx_we = 1'b0; nx_wa = id_ff; nx_wd = id_ff;
      pv_we = 1'b0; pv_wa = id_ff; pv_wd = id_ff;
      sl_we = 1'b0; sl_wd = sl_dec;
      fg_we = 1'b0;
      do_acc = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_acc) begin
               state_in = FSM_READ;
            end
         end
         FSM_READ: begin
            res_pv_in = 1'b0;
            res_pt_in = '0;
            res_rs_in = 1'b0;
            res_st_in = ST_DONE;
            state_in  = FSM_RESP;
            do_acc    = (op_ff == OP_DEQUEUE) || (op_ff == OP_PUT_PREV) ||
                        (op_ff == OP_TICK);
            if (do_acc && cur_valid_ff) begin
               round_in  = acc_round;
               start_in  = now_ff;
               res_rs_in = acc_rs;
            end
            // Unlink a queued task for enqueue, dequeue, yield and put previous
            if (is_q && (op_ff == OP_ENQUEUE || op_ff == OP_DEQUEUE ||
                         op_ff == OP_YIELD || op_ff == OP_PUT_PREV)) begin
               if (id_ff == head_ff) begin
                  head_in = nx_rd_ff;
               end else begin
                  nx_we = 1'b1; nx_wa = pv_rd_ff; nx_wd = nx_rd_ff;
               end
               if (id_ff == tail_ff) begin
                  tail_in = pv_rd_ff;
               end else begin
                  pv_we = 1'b1; pv_wa = nx_rd_ff; pv_wd = pv_rd_ff;
               end
               count_in = count_ff - CNT_W'(1);
            end
            case (op_ff)
               OP_ENQUEUE: begin
                  if (!is_q && count_ff == CNT_W'(MAX_TASKS)) begin
                     res_st_in = ST_FULL;
                  end else begin
                     fg_we = 1'b1;
                     sl_we = 1'b1;
                     sl_wd = fg_req_ff ? fore_ff : back_ff;
                     state_in = FSM_LINK;
                  end
               end
               OP_DEQUEUE: begin
                  if (is_q) begin
                     queued_in[id_ff] = 1'b0;
                  end else begin
                     res_st_in = ST_NOT_QUEUED;
                  end
               end
               OP_YIELD, OP_PUT_PREV: begin
                  if (is_q) begin
                     state_in = FSM_LINK;
                  end else begin
                     res_st_in = ST_NOT_QUEUED;
                  end
               end
               OP_PICK: begin
                  if (count_ff == '0 || round_ff >= budget_ff) begin
                     round_in     = 32'd0;
                     cur_valid_in = 1'b0;
                     res_st_in    = ST_NOT_QUEUED;
                  end else begin
                     res_pv_in    = 1'b1;
                     res_pt_in    = head_ff;
                     start_in     = now_ff;
                     cur_task_in  = head_ff;
                     cur_valid_in = 1'b1;
                  end
               end
               OP_TICK: begin
                  sl_we = 1'b1;
                  if (sl_dec == 16'd0) begin
                     sl_wd = reload;
                     if (!(is_q && id_ff == tail_ff)) begin
                        res_rs_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         FSM_LINK: begin
            // Insert at head (enqueue with at_head) or at tail
            queued_in[id_ff] = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = FSM_RESP;
            if (count_ff == '0) begin
               head_in = id_ff;
               tail_in = id_ff;
            end else if (op_ff == OP_ENQUEUE && head_req_ff) begin
               pv_we = 1'b1; pv_wa = head_ff; pv_wd = id_ff;
               nx_we = 1'b1; nx_wa = id_ff;   nx_wd = head_ff;
               head_in = id_ff;
            end else begin
               nx_we = 1'b1; nx_wa = tail_ff; nx_wd = id_ff;
               pv_we = 1'b1; pv_wa = id_ff;   pv_wd = tail_ff;
               tail_in = id_ff;
            end
         end
         FSM_RESP: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Memories: registered read at acceptance, writes from the sequencer
   always_ff @(posedge clock) begin
      if (req_acc) begin
         nx_rd_ff <= next_mem_ff[req_tdata[8:3]];
         pv_rd_ff <= prev_mem_ff[req_tdata[8:3]];
         sl_rd_ff <= slice_mem_ff[req_tdata[8:3]];
         fg_rd_ff <= fg_mem_ff[req_tdata[8:3]];
      end
      if (nx_we) begin
         next_mem_ff[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_mem_ff[pv_wa] <= pv_wd;
      end
      if (sl_we) begin
         slice_mem_ff[id_ff] <= sl_wd;
      end
      if (fg_we) begin
         fg_mem_ff[id_ff] <= fg_req_ff;
      end
   end

   // Latch the request beat; hold the result and register the response data
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff       <= req_tdata[2:0];
         id_ff       <= req_tdata[8:3];
         head_req_ff <= req_tdata[9];
         fg_req_ff   <= req_tdata[10];
         now_ff      <= req_tdata[42:11];
      end
      res_pv_ff <= res_pv_in;
      res_pt_ff <= res_pt_in;
      res_rs_ff <= res_rs_in;
      res_st_ff <= res_st_in;
      if (state_ff == FSM_RESP && out_free) begin
         rsp_data_ff <= {6'd0, res_st_ff, res_rs_ff, res_pt_ff, res_pv_ff};
      end
   end

   // Control state, configuration and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         queued_ff    <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         round_ff     <= '0;
         start_ff     <= '0;
         cur_task_ff  <= '0;
         cur_valid_ff <= 1'b0;
         fore_ff      <= 16'd100;
         back_ff      <= 16'd10;
         budget_ff    <= 32'd950000000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         queued_ff    <= queued_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         round_ff     <= round_in;
         start_ff     <= start_in;
         cur_task_ff  <= cur_task_in;
         cur_valid_ff <= cur_valid_in;
         if (state_ff == FSM_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_FORE_SLICE:   fore_ff   <= csr_data[15:0];
               REG_BACK_SLICE:   back_ff   <= csr_data[15:0];
               REG_ROUND_BUDGET: budget_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

### tb/round_robin_time_slice_scheduler_test.sv
// Testbench for the round-robin time-slice scheduler: drives queue operations
// through the request stream and checks every response against a built-in predictor.
// Depends on rrts_pkg and round_robin_time_slice_scheduler.
`timescale 1ns / 100ps

module round_robin_time_slice_scheduler_test;
   import rrts_pkg::*;

   typedef struct packed {
      logic [31:0] clock_now;
      logic        foreground;
      logic        at_head;
      logic [5:0]  task_id;
      logic [2:0]  operation;
   } sched_req_t;

   typedef struct packed {
      logic [1:0] status;
      logic       resched;
      logic [5:0] picked_task;
      logic       picked_valid;
   } sched_rsp_t;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   round_robin_time_slice_scheduler uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] fore_slice_q, back_slice_q;
   logic [31:0] budget_q;
   logic [5:0]  run_queue[$];
   logic        queued_q[64];
   logic [15:0] slice_q[64];
   logic        fg_q[64];
   logic [31:0] round_time_q, start_time_q;
   logic        cur_valid_q;
   bit          written_q[64];

   sched_req_t  pending_reqs[$];
   sched_rsp_t  expected_rsps[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   logic [31:0] clock_base = 0;
   bit          stim_done = 1'b0;
   logic        req_tready_seen = 1'b0;

   task automatic report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int queue_pos(logic [5:0] id);
      foreach (run_queue[i]) if (run_queue[i] == id) return i;
      return -1;
   endfunction

   function automatic logic charge_runtime(logic [31:0] now);
      logic [31:0] delta;
      logic [32:0] sum;
      if (!cur_valid_q) return 1'b0;
      delta = now - start_time_q;
      if (delta[31]) delta = 0;
      sum = {1'b0, round_time_q} + {1'b0, delta};
      round_time_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      start_time_q = now;
      return round_time_q >= budget_q;
   endfunction

   // compute the response to one accepted request
   function automatic sched_rsp_t schedule_step(sched_req_t r);
      sched_rsp_t o;
      int p;
      o = '0;
      case (op_type'(r.operation))
         OP_ENQUEUE: begin
            if (queued_q[r.task_id]) begin
               run_queue.delete(queue_pos(r.task_id));
            end else if (run_queue.size() >= MAX_TASKS) begin
               o.status = ST_FULL;
               return o;
            end
            fg_q[r.task_id] = r.foreground;
            slice_q[r.task_id] = r.foreground ? fore_slice_q : back_slice_q;
            if (r.at_head) run_queue.push_front(r.task_id);
            else run_queue.push_back(r.task_id);
            queued_q[r.task_id] = 1'b1;
         end
         OP_DEQUEUE: begin
            o.resched = charge_runtime(r.clock_now);
            if (queued_q[r.task_id]) begin
               run_queue.delete(queue_pos(r.task_id));
               queued_q[r.task_id] = 1'b0;
            end else o.status = ST_NOT_QUEUED;
         end
         OP_YIELD, OP_PUT_PREV: begin
            if (r.operation == OP_PUT_PREV) o.resched = charge_runtime(r.clock_now);
            if (queued_q[r.task_id]) begin
               run_queue.delete(queue_pos(r.task_id));
               run_queue.push_back(r.task_id);
            end else o.status = ST_NOT_QUEUED;
         end
         OP_PICK: begin
            if (run_queue.size() == 0 || round_time_q >= budget_q) begin
               round_time_q = 0;
               cur_valid_q = 1'b0;
               o.status = ST_NOT_QUEUED;
            end else begin
               o.picked_valid = 1'b1;
               o.picked_task = run_queue[0];
               start_time_q = r.clock_now;
               cur_valid_q = 1'b1;
            end
         end
         OP_TICK: begin
            o.resched = charge_runtime(r.clock_now);
            slice_q[r.task_id] = slice_q[r.task_id] - 16'd1;
            if (slice_q[r.task_id] == 0) begin
               slice_q[r.task_id] = fg_q[r.task_id] ? fore_slice_q : back_slice_q;
               p = queue_pos(r.task_id);
               if (!(queued_q[r.task_id] && p == run_queue.size() - 1)) o.resched = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // build one request; ticks only name tasks that were enqueued at some point
   task automatic add_req(logic [2:0] op, logic [5:0] id, logic hd, logic fg,
                          logic [31:0] now);
      sched_req_t r;
      r = {now, fg, hd, id, op};
      if (op == OP_TICK && !written_q[id]) r.operation = OP_YIELD;
      if (op == OP_ENQUEUE) written_q[id] = 1'b1;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [31:0] next_clock();
      clock_base += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400);
      return clock_base;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FORE_SLICE:   fore_slice_q = value[15:0];
         REG_BACK_SLICE:   back_slice_q = value[15:0];
         REG_ROUND_BUDGET: budget_q = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst(int count, int id_span);
      int k;
      logic [2:0] op;
      for (k = 0; k < count; k++) begin
         k = k;
         case ($urandom_range(0, 15))
            0, 1, 2, 3: op = OP_ENQUEUE;
            4, 5:       op = OP_DEQUEUE;
            6:          op = OP_YIELD;
            7, 8, 9:    op = OP_PICK;
            10:         op = OP_PUT_PREV;
            11, 12, 13, 14: op = OP_TICK;
            default:    op = $urandom_range(6, 7);
         endcase
         add_req(op, $urandom_range(0, id_span), $urandom, $urandom, next_clock());
      end
   endtask

   // stimulus
   initial begin
      int i;
      fore_slice_q = 100; back_slice_q = 10; budget_q = 950000000;
      round_time_q = 0; start_time_q = 0; cur_valid_q = 0;
      foreach (queued_q[i]) begin
         queued_q[i] = 0; written_q[i] = 0; slice_q[i] = 0; fg_q[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, corner fields, every operation
      add_req(OP_PICK, 0, 0, 0, 0);
      add_req(OP_DEQUEUE, 5, 0, 0, 32'hFFFF_FFFF);
      add_req(OP_ENQUEUE, 63, 1, 1, 32'hFFFF_FFFF);
      add_req(OP_ENQUEUE, 0, 0, 0, 0);
      add_req(OP_ENQUEUE, 42, 1, 0, 1);
      add_req(OP_ENQUEUE, 63, 0, 0, 2);
      add_req(OP_PICK, 0, 0, 0, 100);
      add_req(OP_TICK, 42, 0, 0, 90);
      add_req(OP_TICK, 63, 0, 0, 32'h8000_0000);
      add_req(OP_YIELD, 42, 0, 0, 0);
      add_req(OP_YIELD, 17, 0, 0, 0);
      add_req(OP_PUT_PREV, 0, 0, 0, 32'h8000_0100);
      add_req(OP_PUT_PREV, 21, 0, 0, 32'h8000_0200);
      add_req(OP_DEQUEUE, 42, 0, 0, 32'h8000_0300);
      add_req(3'd6, 63, 1, 1, 32'hFFFF_FFFF);
      add_req(3'd7, 0, 0, 0, 0);
      wait_drained();

      // tiny slices and budget: slice expiry, budget spent
      write_reg(REG_FORE_SLICE, 1);
      write_reg(REG_BACK_SLICE, 2);
      write_reg(REG_ROUND_BUDGET, 1);
      add_req(OP_ENQUEUE, 7, 0, 1, 0);
      add_req(OP_ENQUEUE, 8, 0, 0, 0);
      add_req(OP_PICK, 0, 0, 0, 10);
      add_req(OP_TICK, 7, 0, 0, 20);
      add_req(OP_TICK, 8, 0, 0, 30);
      add_req(OP_TICK, 8, 0, 0, 40);
      add_req(OP_PICK, 0, 0, 0, 50);
      add_req(OP_PICK, 0, 0, 0, 60);
      wait_drained();

      // fill the queue to full
      write_reg(REG_FORE_SLICE, 16'hFFFF);
      write_reg(REG_BACK_SLICE, 16'hFFFF);
      write_reg(REG_ROUND_BUDGET, 32'hFFFF_FFFF);
      for (i = 0; i < 64; i++) add_req(OP_ENQUEUE, i, $urandom, $urandom, 0);
      add_req(OP_ENQUEUE, 5, 1, 0, 0);
      add_req(OP_PICK, 0, 0, 0, 0);
      add_req(OP_PUT_PREV, 5, 0, 0, 32'hFFFF_FFFF);
      add_req(OP_PUT_PREV, 6, 0, 0, 32'hFFFF_FFFE);
      add_req(OP_DEQUEUE, 9, 0, 0, 32'h7FFF_FFFF);
      add_req(OP_ENQUEUE, 9, 0, 0, 0);
      add_req(OP_ENQUEUE, 9, 0, 0, 0);
      random_burst(150, 63);
      wait_drained();

      // random phases under several settings
      for (i = 0; i < 6; i++) begin
         write_reg(REG_FORE_SLICE, $urandom_range(1, i[0] ? 6 : 40));
         write_reg(REG_BACK_SLICE, $urandom_range(1, 5));
         write_reg(REG_ROUND_BUDGET, i == 5 ? 32'd1 : $urandom_range(200, 20000));
         random_burst(200, i < 3 ? 7 : 63);
         wait_drained();
      end
      stim_done = 1'b1;
   end

   // driver: bursts with random gaps
   int gap_left = 0, burst_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_seen) begin
            // beat taken at the last rising edge; handled by monitor push
         end
         if (!req_tvalid || req_tready_seen) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_tdata <= {5'd0, pending_reqs.pop_front()};
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left <= $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
               end else burst_left <= burst_left - 1;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   logic [7:0] stall_lfsr = 8'h5A;
   always @(negedge clock) begin
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                     ^ stall_lfsr[3]};
      rsp_tready <= stall_lfsr[7:6] != 2'b00 || stall_lfsr[5:0] > 6'd40;
   end

   // monitor: predict on request beats, compare on response beats
   always @(posedge clock) begin
      sched_rsp_t got, want;
      req_tready_seen <= req_tvalid && req_tready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(schedule_step(sched_req_t'(req_tdata[42:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = sched_rsp_t'(rsp_tdata[9:0]);
            if (expected_rsps.size() == 0) begin
               report("unexpected response", got, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.picked_valid !== want.picked_valid)
                  report("picked_valid", got.picked_valid, want.picked_valid);
               if (got.picked_task !== want.picked_task)
                  report("picked_task", got.picked_task, want.picked_task);
               if (got.resched !== want.resched)
                  report("resched", got.resched, want.resched);
               if (got.status !== want.status)
                  report("status", got.status, want.status);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // end of run: wait for the last phase to drain
   initial begin
      wait (stim_done);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_reqs.size() == 0 && expected_rsps.size() == 0 && error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/rrts_pkg.sv
hw/rtl/round_robin_time_slice_scheduler.sv
tb/round_robin_time_slice_scheduler_test.sv
